// File: rtl/lruht_pkg.sv
// ----------------------------------------------------------------------------
// lruht_pkg
// Shared types and constants for the LRU cache hit tracker.
// ----------------------------------------------------------------------------
package lruht_pkg;

	// Fixed widths of the request and result fields.
	localparam int IN_W    = 32;
	localparam int CAP_W   = 9;
	localparam int COUNT_W = 48;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(256);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_UPDATE
	} state_t;

endpackage

// File: rtl/lruht_ram.sv
// ----------------------------------------------------------------------------
// lruht_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lruht_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lru_cache_hit_tracker.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_tracker
// Fully associative cache model with least-recently-used replacement that
// reports, per request, whether the block was held plus running totals.
// ----------------------------------------------------------------------------
// Result: the strobe follows the second sweep (the only sweep when the
// capacity is zero); busy is low in the strobe cycle.
// A new request waits for the last result: each makes two sweeps (one at
// zero capacity) over the entry memory via its one read and one write port.
// Reset: asynchronous; afterwards a clearing pass marks every entry empty
// with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module lru_cache_hit_tracker #(
	parameter int ENTRIES    = 256,
	parameter int BLOCK_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          capacity_we,
	input  logic [lruht_pkg::CAP_W-1:0]   capacity_wdata,
	// Request
	input  logic                          start,
	output logic                          busy,
	input  logic [lruht_pkg::IN_W-1:0]    block_number,
	// Result
	output logic                          done,
	output logic                          hit,
	output logic [lruht_pkg::COUNT_W-1:0] misses_so_far,
	output logic [lruht_pkg::COUNT_W-1:0] hits_so_far
);

	// Entry index, rank and occupancy widths all follow from ENTRIES. A rank
	// runs from 0 (most recent) to ENTRIES-1, so it fits an index.
	localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW     = AW;
	localparam int CNT_W  = AW + 1;
	localparam int OW     = $clog2(ENTRIES + 1);
	localparam int CMPW   = (OW > lruht_pkg::CAP_W) ? OW : lruht_pkg::CAP_W;
	// Only the low BLOCK_BITS of the block number take part in a compare.
	localparam int TAGW   = (BLOCK_BITS < lruht_pkg::IN_W) ? BLOCK_BITS : lruht_pkg::IN_W;
	localparam int WORD_W = 1 + RW + TAGW;

	// Each memory word holds {valid, rank, tag}.
	localparam int V_BIT  = WORD_W - 1;

	lruht_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              cnt_end;
	logic              count_en;

	logic [lruht_pkg::CAP_W-1:0] cap_q;
	logic [CMPW-1:0]   cap_eff;
	logic              cap_zero;
	logic [OW-1:0]     occ_q;
	logic [RW-1:0]     occ_last;

	logic [TAGW-1:0]   key_q;
	logic              wipe_q;
	logic              accept;

	// Read pipeline stage: the word in rdata belongs to idx_s1.
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;

	// Search results gathered over the scan sweep.
	logic              found_q;
	logic [AW-1:0]     found_idx_q;
	logic [RW-1:0]     found_rank_q;
	logic              free_found_q;
	logic [AW-1:0]     free_idx_q;
	logic              vic_found_q;
	logic [AW-1:0]     vic_idx_q;

	// Decisions taken between the sweeps.
	logic              drop_q;
	logic [AW-1:0]     slot_q;

	logic [lruht_pkg::COUNT_W-1:0] miss_total_q;
	logic [lruht_pkg::COUNT_W-1:0] hit_total_q;
	logic              hit_q;
	logic              done_q;

	// Memory ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              rd_v;
	logic [RW-1:0]     rd_rank;
	logic [TAGW-1:0]   rd_tag;
	logic              wr_v;
	logic [RW-1:0]     wr_rank;
	logic [TAGW-1:0]   wr_tag;

	// ------------------------------------------------------------------------
	// Configuration register and derived limits.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lruht_pkg::CAP_RESET;
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	// A capacity above the number of entries behaves as the number of entries.
	assign cap_eff  = (CMPW'(cap_q) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_q);
	assign cap_zero = (cap_q == '0);

	// Rank held by the least recent entry. Meaningless when the cache is empty,
	// but then no valid entry can match it.
	assign occ_last = RW'(occ_q - OW'(1));

	assign accept  = start && (state_q == lruht_pkg::ST_IDLE);
	assign cnt_end = (cnt_q == CNT_W'(ENTRIES));

	// ------------------------------------------------------------------------
	// Sequencer. The clearing pass after reset writes every entry empty. A
	// request sweeps the memory once read-only to find the block, the first
	// free entry and the least recent entry, takes its decisions in the plan
	// state, then sweeps again with read-modify-write to move ranks and place
	// the block. A request made with capacity zero goes straight to the second
	// sweep, which then only empties every entry.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lruht_pkg::ST_CLEAR: begin
				if (cnt_end) state_d = lruht_pkg::ST_IDLE;
			end
			lruht_pkg::ST_IDLE: begin
				if (start) state_d = cap_zero ? lruht_pkg::ST_UPDATE : lruht_pkg::ST_SCAN;
			end
			lruht_pkg::ST_SCAN: begin
				if (cnt_end) state_d = lruht_pkg::ST_PLAN;
			end
			lruht_pkg::ST_PLAN: begin
				state_d = lruht_pkg::ST_UPDATE;
			end
			lruht_pkg::ST_UPDATE: begin
				if (cnt_end) state_d = lruht_pkg::ST_IDLE;
			end
			default: begin
				state_d = lruht_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		count_en = 1'b0;
		ram_re   = 1'b0;
		case (state_q)
			lruht_pkg::ST_CLEAR: begin
				count_en = !cnt_end;
			end
			lruht_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			lruht_pkg::ST_SCAN: begin
				count_en = !cnt_end;
				ram_re   = !cnt_end;
			end
			lruht_pkg::ST_PLAN: begin
				count_en = 1'b0;
			end
			lruht_pkg::ST_UPDATE: begin
				count_en = !cnt_end;
				ram_re   = !cnt_end;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lruht_pkg::ST_CLEAR;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (count_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
	end

	// ------------------------------------------------------------------------
	// Entry memory.
	// ------------------------------------------------------------------------
	assign ram_raddr = cnt_q[AW-1:0];
	assign rd_v      = ram_rdata[V_BIT];
	assign rd_rank   = ram_rdata[V_BIT-1 -: RW];
	assign rd_tag    = ram_rdata[TAGW-1:0];

	// Second-sweep rewrite of one entry. Reads of entry i+1 and the write of
	// entry i fall in the same cycle, so the sweep never reads a stale word.
	always_comb begin
		wr_v    = rd_v;
		wr_rank = rd_rank;
		wr_tag  = rd_tag;
		if (wipe_q) begin
			wr_v = 1'b0;
		end else if (found_q) begin
			// Hit: the block moves to the front, those ahead of it step back.
			if (idx_s1 == found_idx_q) begin
				wr_rank = '0;
			end else if (rd_v && (rd_rank < found_rank_q)) begin
				wr_rank = rd_rank + RW'(1);
			end
		end else begin
			// Miss: the block goes in at the front, everyone else steps back,
			// and the least recent entry leaves first when the cache is full.
			if (idx_s1 == slot_q) begin
				wr_v    = 1'b1;
				wr_rank = '0;
				wr_tag  = key_q;
			end else if (drop_q && (idx_s1 == vic_idx_q)) begin
				wr_v = 1'b0;
			end else if (rd_v) begin
				wr_rank = rd_rank + RW'(1);
			end
		end
	end

	always_comb begin
		if (state_q == lruht_pkg::ST_CLEAR) begin
			ram_we    = !cnt_end;
			ram_waddr = cnt_q[AW-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = vld_s1 && (state_q == lruht_pkg::ST_UPDATE);
			ram_waddr = idx_s1;
			ram_wdata = {wr_v, wr_rank, wr_tag};
		end
	end

	lruht_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------------
	// Request capture and search results. Valid ranks are distinct, so only
	// one entry can carry the least recent rank.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= block_number[TAGW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			drop_q       <= 1'b0;
		end else if (accept) begin
			wipe_q       <= cap_zero;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			vic_found_q  <= 1'b0;
			drop_q       <= 1'b0;
		end else if (state_q == lruht_pkg::ST_SCAN && vld_s1) begin
			if (rd_v && (rd_tag == key_q) && !found_q) begin
				found_q <= 1'b1;
			end
			if (!rd_v && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (rd_v && (rd_rank == occ_last) && !vic_found_q) begin
				vic_found_q <= 1'b1;
			end
		end else if (state_q == lruht_pkg::ST_PLAN) begin
			drop_q <= !found_q && (CMPW'(occ_q) >= cap_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lruht_pkg::ST_SCAN && vld_s1) begin
			if (rd_v && (rd_tag == key_q) && !found_q) begin
				found_idx_q  <= idx_s1;
				found_rank_q <= rd_rank;
			end
			if (!rd_v && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (rd_v && (rd_rank == occ_last) && !vic_found_q) begin
				vic_idx_q <= idx_s1;
			end
		end
		// The new block takes the lowest free entry once the victim is gone.
		if (state_q == lruht_pkg::ST_PLAN) begin
			if (!found_q && (CMPW'(occ_q) >= cap_eff) &&
			    (!free_found_q || (vic_idx_q < free_idx_q))) begin
				slot_q <= vic_idx_q;
			end else begin
				slot_q <= free_idx_q;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Occupancy, totals and the result strobe, all settled as the second
	// sweep writes its last entry.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			miss_total_q <= '0;
			hit_total_q  <= '0;
			hit_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == lruht_pkg::ST_UPDATE && cnt_end) begin
				done_q <= 1'b1;
				hit_q  <= found_q;
				if (wipe_q) begin
					occ_q <= '0;
				end else if (!found_q && !drop_q) begin
					occ_q <= occ_q + OW'(1);
				end
				if (found_q) begin
					if (hit_total_q != lruht_pkg::COUNT_MAX) begin
						hit_total_q <= hit_total_q + lruht_pkg::COUNT_W'(1);
					end
				end else begin
					if (miss_total_q != lruht_pkg::COUNT_MAX) begin
						miss_total_q <= miss_total_q + lruht_pkg::COUNT_W'(1);
					end
				end
			end
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign misses_so_far = miss_total_q;
	assign hits_so_far   = hit_total_q;

endmodule

// File: rtl/lruht_checker.sv
// ----------------------------------------------------------------------------
// lruht_checker
// Port-level checks on the request and result behaviour of the tracker.
// ----------------------------------------------------------------------------
module lruht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          hit,
	input logic [lruht_pkg::COUNT_W-1:0] misses_so_far,
	input logic [lruht_pkg::COUNT_W-1:0] hits_so_far
);

	// An accepted request keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy afterwards");

	// A result is shown only once the block is ready for the next request.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// The strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// The totals move only with a result.
	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> ($stable(misses_so_far) && $stable(hits_so_far)) || done)
		else $error("totals changed without a result");

	// A reported hit or miss is counted in its own total.
	a_total_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit ? (hits_so_far != '0) : (misses_so_far != '0)))
		else $error("result not reflected in its total");

endmodule

bind lru_cache_hit_tracker lruht_checker u_lruht_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.misses_so_far (misses_so_far),
	.hits_so_far   (hits_so_far)
);

// File: bench/lruht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruht_scoreboard
// Follows every request and capacity write seen on the ports of the LRU cache
// hit tracker. It keeps its own copy of the cache contents and recency ranks,
// works out the outcome of each request, and compares each result against the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module lruht_scoreboard #(
	parameter int ENTRIES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          capacity_we,
	input  logic [lruht_pkg::CAP_W-1:0]   capacity_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic [lruht_pkg::IN_W-1:0]    block_number,
	input  logic                          done,
	input  logic                          hit,
	input  logic [lruht_pkg::COUNT_W-1:0] misses_so_far,
	input  logic [lruht_pkg::COUNT_W-1:0] hits_so_far,
	output int                            fail_count,
	output int                            pending
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic                          hit;
		logic [lruht_pkg::COUNT_W-1:0] misses;
		logic [lruht_pkg::COUNT_W-1:0] hits;
	} lookup_outcome_t;

	// Shadow copy of the cache.
	logic [lruht_pkg::IN_W-1:0]    shadow_tag   [ENTRIES];
	logic                          shadow_valid [ENTRIES];
	logic [RANK_W-1:0]             shadow_rank  [ENTRIES];
	logic [lruht_pkg::CAP_W-1:0]   shadow_occupancy;
	logic [lruht_pkg::CAP_W-1:0]   shadow_capacity;
	logic [lruht_pkg::COUNT_W-1:0] shadow_misses;
	logic [lruht_pkg::COUNT_W-1:0] shadow_hits;

	lookup_outcome_t predicted_lookups[$];
	int              results_seen;

	// Applies one access to the shadow cache and returns the result it yields.
	function automatic lookup_outcome_t access_cache(logic [lruht_pkg::IN_W-1:0] blk);
		int              eff_cap;
		int              found;
		int              slot;
		logic [RANK_W-1:0] old_rank;
		lookup_outcome_t outcome;
		eff_cap = (int'(shadow_capacity) > ENTRIES) ? ENTRIES : int'(shadow_capacity);
		found = -1;
		slot = -1;
		outcome.hit = 1'b0;
		if (eff_cap == 0) begin
			// Zero capacity flushes everything and inserts nothing.
			for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
			shadow_occupancy = '0;
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (shadow_valid[i] && shadow_tag[i] == blk) begin
					found = i;
					break;
				end
			end
			if (found >= 0) begin
				// Entries more recent than the hit age by one.
				old_rank = shadow_rank[found];
				outcome.hit = 1'b1;
				for (int i = 0; i < ENTRIES; i++)
					if (shadow_valid[i] && shadow_rank[i] < old_rank)
						shadow_rank[i] = shadow_rank[i] + RANK_W'(1);
				shadow_rank[found] = '0;
			end else begin
				// A full (or over-full) cache loses exactly one block per miss.
				if (int'(shadow_occupancy) >= eff_cap && shadow_occupancy != '0) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (shadow_valid[i] && lruht_pkg::CAP_W'(shadow_rank[i]) ==
						    shadow_occupancy - lruht_pkg::CAP_W'(1)) begin
							shadow_valid[i] = 1'b0;
							shadow_occupancy = shadow_occupancy - lruht_pkg::CAP_W'(1);
							break;
						end
					end
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (shadow_valid[i])
						shadow_rank[i] = shadow_rank[i] + RANK_W'(1);
					else if (slot < 0)
						slot = i;
				end
				if (slot >= 0) begin
					shadow_valid[slot] = 1'b1;
					shadow_tag[slot] = blk;
					shadow_rank[slot] = '0;
					shadow_occupancy = shadow_occupancy + lruht_pkg::CAP_W'(1);
				end
			end
		end
		if (outcome.hit) begin
			if (shadow_hits != lruht_pkg::COUNT_MAX)
				shadow_hits = shadow_hits + lruht_pkg::COUNT_W'(1);
		end else begin
			if (shadow_misses != lruht_pkg::COUNT_MAX)
				shadow_misses = shadow_misses + lruht_pkg::COUNT_W'(1);
		end
		outcome.misses = shadow_misses;
		outcome.hits = shadow_hits;
		return outcome;
	endfunction

	// Prints one line per mismatch and counts every one.
	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) shadow_valid[i] = 1'b0;
			shadow_occupancy = '0;
			shadow_capacity = lruht_pkg::CAP_RESET;
			shadow_misses = '0;
			shadow_hits = '0;
			predicted_lookups.delete();
			results_seen = 0;
			pending = 0;
			fail_count = 0;
		end else begin
			if (done) begin
				if (predicted_lookups.size() == 0) begin
					report_mismatch($sformatf("result %0d with no request outstanding",
						results_seen));
				end else begin
					want = predicted_lookups.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("result %0d: hit %b, expected %b",
							results_seen, hit, want.hit));
					if (misses_so_far !== want.misses)
						report_mismatch($sformatf("result %0d: misses %0d, expected %0d",
							results_seen, misses_so_far, want.misses));
					if (hits_so_far !== want.hits)
						report_mismatch($sformatf("result %0d: hits %0d, expected %0d",
							results_seen, hits_so_far, want.hits));
				end
				results_seen++;
			end
			if (capacity_we)
				shadow_capacity = capacity_wdata;
			if (start && !busy)
				predicted_lookups.push_back(access_cache(block_number));
			pending = predicted_lookups.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LRU cache hit tracker. A short directed run
// covers the block-number extremes and the capacity corner cases; random
// phases then replay small pools of block numbers under varied capacities so
// that hits, evictions and shrinking capacities all occur. Checking is done by
// lruht_scoreboard, which sits beside the block on the same ports.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ENTRIES     = 256;
	localparam int BLOCK_BITS  = 32;
	localparam int REQUESTS    = 1450;
	localparam int MAX_GAP     = 12;
	// The limit is several times the longest quiet stretch: a request plus a gap.
	localparam int IDLE_LIMIT  = 10 * (2 * ENTRIES + 4 + MAX_GAP);
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

	logic                          clk;
	logic                          arst_n;
	logic                          capacity_we;
	logic [lruht_pkg::CAP_W-1:0]   capacity_wdata;
	logic                          start;
	logic                          busy;
	logic [lruht_pkg::IN_W-1:0]    block_number;
	logic                          done;
	logic                          hit;
	logic [lruht_pkg::COUNT_W-1:0] misses_so_far;
	logic [lruht_pkg::COUNT_W-1:0] hits_so_far;

	int fail_count;
	int pending;
	int sent;

	lru_cache_hit_tracker #(
		.ENTRIES    (ENTRIES),
		.BLOCK_BITS (BLOCK_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.start          (start),
		.busy           (busy),
		.block_number   (block_number),
		.done           (done),
		.hit            (hit),
		.misses_so_far  (misses_so_far),
		.hits_so_far    (hits_so_far)
	);

	lruht_scoreboard #(
		.ENTRIES (ENTRIES)
	) u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.start          (start),
		.busy           (busy),
		.block_number   (block_number),
		.done           (done),
		.hit            (hit),
		.misses_so_far  (misses_so_far),
		.hits_so_far    (hits_so_far),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Issues one request with a freshly drawn wait. If max_gap is non-zero,
	// half of the requests first let the block go idle, so that the gap lands
	// after busy falls rather than being swallowed by the busy period. With a
	// zero gap and no idle wait, start simply stays high and the payload changes.
	task automatic issue_request(input logic [lruht_pkg::IN_W-1:0] blk, input int max_gap);
		int gap;
		bit hold_idle;
		gap = int'($urandom_range(0, max_gap));
		hold_idle = (max_gap > 0) && ($urandom_range(0, 1) == 1);
		@(negedge clk);
		if (gap > 0 || hold_idle) begin
			start <= 1'b0;
			do @(negedge clk); while (hold_idle && busy);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		block_number <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// Capacity is only changed with the block idle: the sender stops and
	// waits for every outstanding result before the write goes in.
	task automatic write_capacity(input logic [lruht_pkg::CAP_W-1:0] value);
		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= value;
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	// Watchdog: ends the run after too long with no request, result or write.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || capacity_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [lruht_pkg::IN_W-1:0]  pool[$];
		logic [lruht_pkg::IN_W-1:0]  blk;
		logic [lruht_pkg::CAP_W-1:0] cap;
		int                          eff_cap;
		int                          phase;
		int                          run_len;
		int                          pool_size;
		int                          max_gap;
		int                          pick;

		arst_n = 1'b0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		start = 1'b0;
		block_number = '0;
		sent = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Let the clearing pass finish before anything is sent.
		repeat (2) @(negedge clk);
		while (busy) @(negedge clk);

		// Directed part, reset capacity first: both extremes of the block
		// number miss and then hit, and a hit in the middle of the ranks.
		issue_request(32'h0000_0000, MAX_GAP);
		issue_request(32'hFFFF_FFFF, MAX_GAP);
		issue_request(32'h0000_0000, MAX_GAP);
		issue_request(32'hFFFF_FFFF, MAX_GAP);
		issue_request(32'h8000_0000, MAX_GAP);
		issue_request(32'h7FFF_FFFF, MAX_GAP);
		issue_request(32'hFFFF_FFFF, MAX_GAP);

		// Capacity dropped below the occupancy: each miss loses one block,
		// hits lose none.
		write_capacity(lruht_pkg::CAP_W'(1));
		issue_request(32'hA5A5_A5A5, MAX_GAP);
		issue_request(32'hA5A5_A5A5, MAX_GAP);
		issue_request(32'h5A5A_5A5A, MAX_GAP);
		issue_request(32'h0000_0000, MAX_GAP);

		// Zero capacity: everything misses and the cache is emptied.
		write_capacity(lruht_pkg::CAP_W'(0));
		issue_request(32'h0000_0000, MAX_GAP);
		issue_request(32'h0000_0000, MAX_GAP);

		// Small capacity with a plain eviction of the least recent block.
		write_capacity(lruht_pkg::CAP_W'(2));
		issue_request(32'h0000_0001, MAX_GAP);
		issue_request(32'h0000_0002, MAX_GAP);
		issue_request(32'h0000_0001, MAX_GAP);
		issue_request(32'h0000_0003, MAX_GAP);
		issue_request(32'h0000_0002, MAX_GAP);

		// Capacity above the entry count behaves as the entry count.
		write_capacity(lruht_pkg::CAP_W'(511));
		issue_request(32'h0000_0003, MAX_GAP);
		issue_request(32'h0000_0002, MAX_GAP);

		// Random phases. The first one fills the whole cache and forces
		// evictions at full size; the next shrinks the capacity hard while
		// the cache is full, and the next five use fixed corner capacities. Later
		// ones draw it at random, mostly small so hits and evictions both stay frequent.
		phase = 0;
		while (sent < REQUESTS) begin
			case (phase)
				0: cap = lruht_pkg::CAP_W'(511);
				1: cap = lruht_pkg::CAP_W'(3);
				2: cap = lruht_pkg::CAP_W'(0);
				3: cap = lruht_pkg::CAP_W'(256);
				4: cap = lruht_pkg::CAP_W'(1);
				5: cap = lruht_pkg::CAP_W'(257);
				6: cap = lruht_pkg::CAP_W'(255);
				default: begin
					pick = int'($urandom_range(0, 9));
					if (pick == 0)
						cap = '0;
					else if (pick <= 2)
						cap = lruht_pkg::CAP_W'($urandom_range(0, 511));
					else if (pick == 3)
						cap = lruht_pkg::CAP_W'($urandom_range(256, 511));
					else
						cap = lruht_pkg::CAP_W'($urandom_range(1, 16));
				end
			endcase
			write_capacity(cap);
			eff_cap = (int'(cap) > ENTRIES) ? ENTRIES : int'(cap);

			if (phase == 0) begin
				run_len = 450;
				pool_size = 400;
			end else begin
				run_len = int'($urandom_range(30, 90));
				pool_size = int'($urandom_range(1, eff_cap + eff_cap / 2 + 2));
			end
			// Some phases run back to back with no idle cycles at all.
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;

			pool.delete();
			repeat (pool_size) pool.push_back($urandom());

			for (int k = 0; k < run_len && sent < REQUESTS; k++) begin
				// Mostly reuse of the pool, with some fresh block numbers.
				if ($urandom_range(0, 99) < 85)
					blk = pool[$urandom_range(0, pool.size() - 1)];
				else
					blk = $urandom();
				issue_request(blk, max_gap);
			end
			phase++;
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		// Stay a while longer so a stray extra result would still be caught.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
